// ----- design/taysc_pkg.sv -----
// ----------------------------------------------------------------------------
// taysc_pkg
// Shared widths, codes and arithmetic helpers for the Taylor sine/cosine unit.
// ----------------------------------------------------------------------------
package taysc_pkg;

	localparam int FRAC_BITS     = 28;
	localparam int RECIP_BITS    = 32;
	localparam int ANGLE_W       = 32;
	localparam int VALUE_W       = 30;
	localparam int MAG_W         = FRAC_BITS + 3;
	localparam int X2_W          = FRAC_BITS + 5;
	localparam int M_W           = 32;
	localparam int F_W           = 32;
	localparam int ACC_W         = 36;
	localparam int LAST_TERM_DEF = 50;

	localparam logic [MAG_W-1:0] ANGLE_LIM = MAG_W'(4) << FRAC_BITS;
	localparam logic [M_W-1:0]   ONE_M     = M_W'(1) << FRAC_BITS;

	typedef enum logic {
		FUNC_SIN = 1'b0,
		FUNC_COS = 1'b1
	} func_t;

	// Series divisor for term k
	function automatic longint unsigned term_div(input int k, input bit is_cos);
		longint unsigned kk;
		kk = longint'(k);
		return is_cos ? (2 * kk - 1) * (2 * kk) : (2 * kk) * (2 * kk + 1);
	endfunction

	// x2 = round(mag^2 / 2^FRAC_BITS)
	function automatic logic [X2_W-1:0] square_rnd(input logic [MAG_W-1:0] mag);
		logic [2*MAG_W:0] p;
		p = (2*MAG_W+1)'(mag) * (2*MAG_W+1)'(mag) + ((2*MAG_W+1)'(1) << (FRAC_BITS - 1));
		return p[FRAC_BITS +: X2_W];
	endfunction

	// f = round(x2 * R / 2^RECIP_BITS)
	function automatic logic [F_W-1:0] factor_rnd(input logic [X2_W-1:0] x2,
			input logic [RECIP_BITS-1:0] r);
		logic [X2_W+RECIP_BITS-1:0] p;
		p = (X2_W+RECIP_BITS)'(x2) * (X2_W+RECIP_BITS)'(r)
			+ ((X2_W+RECIP_BITS)'(1) << (RECIP_BITS - 1));
		return p[RECIP_BITS +: F_W];
	endfunction

	// m' = round(m * f / 2^FRAC_BITS)
	function automatic logic [M_W-1:0] term_rnd(input logic [M_W-1:0] m,
			input logic [F_W-1:0] f);
		logic [M_W+F_W-1:0] p;
		p = (M_W+F_W)'(m) * (M_W+F_W)'(f) + ((M_W+F_W)'(1) << (FRAC_BITS - 1));
		return p[FRAC_BITS +: M_W];
	endfunction

	// Signed term from magnitude and sign
	function automatic logic signed [ACC_W-1:0] signed_term(input logic [M_W-1:0] m,
			input logic neg);
		logic signed [ACC_W-1:0] e;
		e = $signed({{(ACC_W-M_W){1'b0}}, m});
		return neg ? -e : e;
	endfunction

endpackage

// ----- design/taylor_sine_cosine.sv -----
// ----------------------------------------------------------------------------
// taylor_sine_cosine
// Pipelined Maclaurin-series sine and cosine, fixed point with 28 fraction bits.
// ----------------------------------------------------------------------------
//  channel   ports                 handshake
//  -------   -------------------   ------------------------------------------
//  command   func, angle           taken when start is high and busy is low
//  result    value                 valid for one cycle while done is high
//
//  One word enters per cycle; busy stays low.
//  Each word passes through one stage per series term plus the clamp,
//  square, first factor and sum/saturate stages.
//  arst_n clears the valid bits; words in flight are dropped.
//  The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module taylor_sine_cosine #(
	parameter int LAST_TERM = taysc_pkg::LAST_TERM_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 func,
	input  logic signed [taysc_pkg::ANGLE_W-1:0] angle,
	output logic                                 done,
	output logic signed [taysc_pkg::VALUE_W-1:0] value
);

	localparam int L = LAST_TERM;

	logic                            neg_in;
	logic [taysc_pkg::ANGLE_W:0]     abs_in;
	logic [taysc_pkg::MAG_W-1:0]     mag_in;
	logic                            cos_in;

	logic                            vld_s1;
	logic [taysc_pkg::MAG_W-1:0]     mag_s1;
	logic                            cos_s1;
	logic                            flip_s1;

	logic                            vld_s2;
	logic [taysc_pkg::X2_W-1:0]      x2_s2;
	logic [taysc_pkg::M_W-1:0]       m0_s2;
	logic                            cos_s2;
	logic                            flip_s2;

	logic                            vld_s   [0:L];
	logic [taysc_pkg::M_W-1:0]       m_s     [0:L];
	logic signed [taysc_pkg::ACC_W-1:0] acc_s [0:L];
	logic                            flip_s  [0:L];
	logic [taysc_pkg::F_W-1:0]       f_s     [0:L-1];
	logic [taysc_pkg::X2_W-1:0]      x2_s    [0:L-2];
	logic                            cos_s   [0:L-2];

	logic signed [taysc_pkg::ACC_W-1:0] acc_fin;
	logic signed [taysc_pkg::ACC_W-1:0] one_acc;
	logic signed [taysc_pkg::ACC_W-1:0] neg_one_acc;
	logic                            done_q;
	logic signed [taysc_pkg::VALUE_W-1:0] value_q;

	assign busy = 1'b0;

	assign cos_in = (taysc_pkg::func_t'(func) == taysc_pkg::FUNC_COS);
	assign neg_in = angle[taysc_pkg::ANGLE_W-1];
	assign abs_in = neg_in ? -{1'b1, angle} : {1'b0, angle};
	assign mag_in = (abs_in > (taysc_pkg::ANGLE_W+1)'(taysc_pkg::ANGLE_LIM))
		? taysc_pkg::ANGLE_LIM : abs_in[taysc_pkg::MAG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s[0] <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		mag_s1  <= mag_in;
		cos_s1  <= cos_in;
		flip_s1 <= !cos_in && neg_in;

		x2_s2   <= taysc_pkg::square_rnd(mag_s1);
		m0_s2   <= cos_s1 ? taysc_pkg::ONE_M
			: {{(taysc_pkg::M_W-taysc_pkg::MAG_W){1'b0}}, mag_s1};
		cos_s2  <= cos_s1;
		flip_s2 <= flip_s1;
	end

	// first factor, term 1
	localparam longint unsigned DS1 = taysc_pkg::term_div(1, 1'b0);
	localparam longint unsigned DC1 = taysc_pkg::term_div(1, 1'b1);
	localparam logic [63:0] RS1_FULL = ((64'd1 << taysc_pkg::RECIP_BITS) + DS1 / 2) / DS1;
	localparam logic [63:0] RC1_FULL = ((64'd1 << taysc_pkg::RECIP_BITS) + DC1 / 2) / DC1;

	always_ff @(posedge clk) begin
		m_s[0]    <= m0_s2;
		acc_s[0]  <= '0;
		flip_s[0] <= flip_s2;
		f_s[0]    <= taysc_pkg::factor_rnd(x2_s2,
			cos_s2 ? RC1_FULL[taysc_pkg::RECIP_BITS-1:0]
			: RS1_FULL[taysc_pkg::RECIP_BITS-1:0]);
		x2_s[0]   <= x2_s2;
		cos_s[0]  <= cos_s2;
	end

	for (genvar t = 0; t < L; t++) begin : g_term
		localparam bit ODD = (t % 2) == 1;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[t+1] <= 1'b0;
			end else begin
				vld_s[t+1] <= vld_s[t];
			end
		end

		always_ff @(posedge clk) begin
			m_s[t+1]    <= taysc_pkg::term_rnd(m_s[t], f_s[t]);
			acc_s[t+1]  <= acc_s[t] + taysc_pkg::signed_term(m_s[t], ODD ^ flip_s[t]);
			flip_s[t+1] <= flip_s[t];
		end

		if (t + 2 <= L) begin : g_fac
			localparam longint unsigned DS = taysc_pkg::term_div(t + 2, 1'b0);
			localparam longint unsigned DC = taysc_pkg::term_div(t + 2, 1'b1);
			localparam logic [63:0] RS_FULL =
				((64'd1 << taysc_pkg::RECIP_BITS) + DS / 2) / DS;
			localparam logic [63:0] RC_FULL =
				((64'd1 << taysc_pkg::RECIP_BITS) + DC / 2) / DC;

			always_ff @(posedge clk) begin
				f_s[t+1] <= taysc_pkg::factor_rnd(x2_s[t],
					cos_s[t] ? RC_FULL[taysc_pkg::RECIP_BITS-1:0]
					: RS_FULL[taysc_pkg::RECIP_BITS-1:0]);
			end
		end

		if (t + 1 <= L - 2) begin : g_fwd
			always_ff @(posedge clk) begin
				x2_s[t+1]  <= x2_s[t];
				cos_s[t+1] <= cos_s[t];
			end
		end
	end

	localparam bit LAST_ODD = (L % 2) == 1;

	assign one_acc     = $signed(taysc_pkg::ACC_W'(1) << taysc_pkg::FRAC_BITS);
	assign neg_one_acc = -one_acc;
	assign acc_fin = acc_s[L] + taysc_pkg::signed_term(m_s[L], LAST_ODD ^ flip_s[L]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s[L];
		end
	end

	always_ff @(posedge clk) begin
		if (acc_fin > one_acc) begin
			value_q <= one_acc[taysc_pkg::VALUE_W-1:0];
		end else if (acc_fin < neg_one_acc) begin
			value_q <= neg_one_acc[taysc_pkg::VALUE_W-1:0];
		end else begin
			value_q <= acc_fin[taysc_pkg::VALUE_W-1:0];
		end
	end

	assign done  = done_q;
	assign value = value_q;

endmodule

// ----- design/taysc_checker.sv -----
// ----------------------------------------------------------------------------
// taysc_checker
// Port-level checks on busy, latency, range and a known cosine point.
// ----------------------------------------------------------------------------
module taysc_checker #(
	parameter int LAST_TERM = taysc_pkg::LAST_TERM_DEF
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 start,
	input logic                                 busy,
	input logic                                 func,
	input logic signed [taysc_pkg::ANGLE_W-1:0] angle,
	input logic                                 done,
	input logic signed [taysc_pkg::VALUE_W-1:0] value
);

	localparam int LAT = LAST_TERM + 4;
	localparam logic signed [taysc_pkg::VALUE_W-1:0] ONE_V =
		taysc_pkg::VALUE_W'(1) << taysc_pkg::FRAC_BITS;

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("word accepted but no result at expected latency");

	a_done_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without matching accepted word");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (value <= ONE_V) && (value >= -ONE_V))
		else $error("result outside unit range");

	a_cos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (taysc_pkg::func_t'(func) == taysc_pkg::FUNC_COS)
		&& (angle == '0) |-> ##LAT (value == ONE_V))
		else $error("cosine of zero is not one");

endmodule

bind taylor_sine_cosine taysc_checker #(.LAST_TERM(LAST_TERM)) u_taysc_checker (.*);
